[rtl/core/nmea_line_checksum_checker_top_macros.svh]
// ----------------------------------------------------------------------------
// nmea line checksum checker assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef NMEA_LINE_CHECKSUM_CHECKER_TOP_MACROS_SVH
`define NMEA_LINE_CHECKSUM_CHECKER_TOP_MACROS_SVH

// clocked assertion, off while reset is high
`define NLCC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, live through reset
`define NLCC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/nlcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcc_pkg
// shared types, constants and helpers of the nmea line checksum checker
// ----------------------------------------------------------------------------
package nlcc_pkg;

  localparam int MAX_LINE = 128;
  localparam int LEN_W    = 8;
  localparam int CNT_W    = LEN_W + 1;
  localparam int STATUS_W = 3;
  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_HEX_A_OFS = 8'h37;  // 'A' - 10
  localparam logic [3:0] NIB_TEN = 4'hA;

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_SUM  = 3'd1,
    ST_SHORT    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_TIMEOUT  = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    EV_LINE,
    EV_TIMEOUT,
    EV_OVERFLOW
  } event_kind_t;

  // one line event handed from the framer to the checker
  typedef struct packed {
    event_kind_t      kind;
    logic [LEN_W-1:0] len;
    logic [7:0]       sum;
    logic [7:0]       dig_hi;
    logic [7:0]       dig_lo;
    logic             star_ok;
  } line_rec_t;

  typedef struct packed {
    logic      push;
    line_rec_t rec;
  } q_wr_t;

  typedef struct packed {
    logic      valid;
    line_rec_t rec;
  } q_rd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < NIB_TEN) begin
      return CH_ZERO + {4'h0, nib};
    end
    return CH_HEX_A_OFS + {4'h0, nib};
  endfunction

endpackage

[rtl/core/nlcc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcc channel interfaces
// valid/ready channels for received bytes and line status results
// ----------------------------------------------------------------------------
interface nlcc_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface nlcc_res_if;
  logic                          valid;
  logic                          ready;
  logic [nlcc_pkg::STATUS_W-1:0] line_status;
  logic [nlcc_pkg::LEN_W-1:0]    line_length;
  logic [7:0]                    computed_sum;

  modport source (output valid, output line_status, output line_length,
                  output computed_sum, input ready);
  modport sink   (input valid, input line_status, input line_length,
                  input computed_sum, output ready);
endinterface

[rtl/core/nmea_line_checksum_checker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_line_checksum_checker_top
// frames cr lf terminated sentences and checks the trailing xor checksum
// ----------------------------------------------------------------------------
// Feed one received byte or one timeout event per transaction on req; one
// transaction is taken every clock cycle while the event queue has room, and
// each line end, timeout or overflow yields one status transaction on res
// through the queue write and then the output register. The byte framer keeps
// all line state; the checksum verdict runs in the back stage, so a stalled
// res only blocks req once the two-entry event queue and the output register
// are full. An overflow reports at once with length 128, after which bytes
// are dropped silently up to the next cr lf. check_enable is written through
// cfg_wr_en / cfg_wr_data and resets to on; the user must write it only while
// no line result is outstanding, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module nmea_line_checksum_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  nlcc_req_if.sink    req,
  nlcc_res_if.source  res
);
  import nlcc_pkg::*;

  // checksum enable, verify on by default
  logic check_enable;

  // framer to queue, queue to checker
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      check_enable <= cfg_wr_data;
    end
  end

  // front: byte classification, counts, running xor, discard tracking
  nlcc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // decouples framing from result backpressure
  nlcc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .full (q_full),
    .q_rd (q_rd),
    .pop  (q_pop)
  );

  // back: hex digit compare, status pick, output register
  nlcc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .check_enable (check_enable),
    .q_rd         (q_rd),
    .pop          (q_pop),
    .res          (res)
  );

endmodule

[rtl/core/nlcc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcc_front
// line framer: tracks line state per byte, queues timeout and overflow events and one event per kept line end
// ----------------------------------------------------------------------------
module nlcc_front (
  input  logic          clk,
  input  logic          rst,
  nlcc_req_if.sink      req,
  input  logic          q_full,
  output nlcc_pkg::q_wr_t q_wr
);
  import nlcc_pkg::*;

  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [7:0]       recent_bytes [4];
  logic [7:0]       recent_bytes_next [4];
  logic             discarding, discarding_next;

  logic             accept;
  logic             pending;
  logic             is_cr;
  logic             is_lf;
  logic             first;
  logic [CNT_W-1:0] count_wide;
  logic [CNT_W-1:0] seen_wide;

  assign req.ready = !q_full;
  assign accept    = req.valid && !q_full;
  assign pending   = (recent_bytes[0] == CH_CR);
  assign is_cr     = (req.rx_byte == CH_CR);
  assign is_lf     = (req.rx_byte == CH_LF);
  assign first     = (byte_count == '0) && !pending;
  assign seen_wide = CNT_W'(byte_count) + CNT_W'(pending);
  assign count_wide = seen_wide + CNT_W'(!is_cr);

  always_comb begin
    byte_count_next  = byte_count;
    running_xor_next = running_xor;
    discarding_next  = discarding;
    for (int i = 0; i < 4; i++) begin
      recent_bytes_next[i] = recent_bytes[i];
    end
    q_wr             = '0;
    q_wr.rec.kind    = EV_LINE;
    q_wr.rec.sum     = running_xor ^ CH_CR ^ recent_bytes[1] ^ recent_bytes[2]
                       ^ recent_bytes[3];
    q_wr.rec.dig_hi  = recent_bytes[2];
    q_wr.rec.dig_lo  = recent_bytes[1];
    q_wr.rec.star_ok = (recent_bytes[3] == CH_STAR);
    q_wr.rec.len     = byte_count;

    if (accept) begin
      if (req.req_type == REQ_TIMEOUT) begin
        q_wr.push     = 1'b1;
        q_wr.rec.kind = EV_TIMEOUT;
        if (discarding) begin
          q_wr.rec.len = '0;
        end else if (seen_wide > CNT_W'(MAX_LINE)) begin
          q_wr.rec.len = LEN_W'(MAX_LINE);
        end else begin
          q_wr.rec.len = seen_wide[LEN_W-1:0];
        end
        discarding_next  = 1'b0;
        byte_count_next  = '0;
        running_xor_next = '0;
        for (int i = 0; i < 4; i++) begin
          recent_bytes_next[i] = '0;
        end
      end else if (discarding) begin
        if (pending && is_lf) begin
          discarding_next  = 1'b0;
          byte_count_next  = '0;
          running_xor_next = '0;
          for (int i = 0; i < 4; i++) begin
            recent_bytes_next[i] = '0;
          end
        end else begin
          for (int i = 1; i < 4; i++) begin
            recent_bytes_next[i] = recent_bytes[i-1];
          end
          recent_bytes_next[0] = req.rx_byte;
        end
      end else if (pending && is_lf) begin
        // line end, checker finishes the verdict
        q_wr.push        = 1'b1;
        byte_count_next  = '0;
        running_xor_next = '0;
        for (int i = 0; i < 4; i++) begin
          recent_bytes_next[i] = '0;
        end
      end else if (count_wide > CNT_W'(MAX_LINE)) begin
        q_wr.push        = 1'b1;
        q_wr.rec.kind    = EV_OVERFLOW;
        q_wr.rec.len     = LEN_W'(MAX_LINE);
        discarding_next  = 1'b1;
        byte_count_next  = '0;
        running_xor_next = '0;
        for (int i = 1; i < 4; i++) begin
          recent_bytes_next[i] = '0;
        end
        recent_bytes_next[0] = req.rx_byte;
      end else begin
        if (!first) begin
          running_xor_next = running_xor ^ req.rx_byte;
        end
        byte_count_next = count_wide[LEN_W-1:0];
        for (int i = 1; i < 4; i++) begin
          recent_bytes_next[i] = recent_bytes[i-1];
        end
        recent_bytes_next[0] = req.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_xor <= '0;
      discarding  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        recent_bytes[i] <= '0;
      end
    end else begin
      byte_count  <= byte_count_next;
      running_xor <= running_xor_next;
      discarding  <= discarding_next;
      for (int i = 0; i < 4; i++) begin
        recent_bytes[i] <= recent_bytes_next[i];
      end
    end
  end

endmodule

[rtl/core/nlcc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcc_queue
// small fifo of line events between framer and checker
// ----------------------------------------------------------------------------
module nlcc_queue (
  input  logic            clk,
  input  logic            rst,
  input  nlcc_pkg::q_wr_t q_wr,
  output logic            full,
  output nlcc_pkg::q_rd_t q_rd,
  input  logic            pop
);
  import nlcc_pkg::*;

  line_rec_t         entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(Q_DEPTH));
  assign q_rd.valid = (count != '0);
  assign q_rd.rec   = entries[rd_ptr];
  assign do_push    = q_wr.push && !full;
  assign do_pop     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_wr.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

[rtl/core/nlcc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcc_back
// checksum verdict and registered result output
// ----------------------------------------------------------------------------
module nlcc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            check_enable,
  input  nlcc_pkg::q_rd_t q_rd,
  output logic            pop,
  nlcc_res_if.source      res
);
  import nlcc_pkg::*;

  logic             out_valid;
  status_t          out_status;
  logic [LEN_W-1:0] out_length;
  logic [7:0]       out_sum;

  status_t          status_c;
  logic [7:0]       sum_c;
  logic             sum_ok;

  assign pop = q_rd.valid && (!out_valid || res.ready);

  assign sum_ok = q_rd.rec.star_ok
               && (q_rd.rec.dig_hi == hex_char(q_rd.rec.sum[7:4]))
               && (q_rd.rec.dig_lo == hex_char(q_rd.rec.sum[3:0]));

  always_comb begin
    status_c = ST_OK;
    sum_c    = '0;
    case (q_rd.rec.kind)
      EV_LINE: begin
        if (q_rd.rec.len == '0) begin
          status_c = ST_EMPTY;
        end else if (!check_enable) begin
          status_c = ST_OK;
        end else if (q_rd.rec.len < LEN_W'(4)) begin
          status_c = ST_SHORT;
        end else begin
          sum_c    = q_rd.rec.sum;
          status_c = sum_ok ? ST_OK : ST_BAD_SUM;
        end
      end
      EV_TIMEOUT:  status_c = ST_TIMEOUT;
      EV_OVERFLOW: status_c = ST_OVERFLOW;
      default:     status_c = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_status <= status_c;
      out_length <= q_rd.rec.len;
      out_sum    <= sum_c;
    end
  end

  assign res.valid        = out_valid;
  assign res.line_status  = out_status;
  assign res.line_length  = out_length;
  assign res.computed_sum = out_sum;

endmodule

[rtl/core/nlcc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlcc_checker
// port level assertions on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "nmea_line_checksum_checker_top_macros.svh"

module nlcc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [nlcc_pkg::STATUS_W-1:0] line_status,
  input logic [nlcc_pkg::LEN_W-1:0]    line_length,
  input logic [7:0]                    computed_sum
);
  import nlcc_pkg::*;

  `NLCC_ASSERT_ALWAYS(a_idle_after_rst, clk, $past(rst) |-> !res_valid, "result valid after reset")

  `NLCC_ASSERT(a_hold_stall, clk, rst, res_valid && !res_ready |=> res_valid && $stable(line_status) && $stable(line_length) && $stable(computed_sum), "stalled result changed")

  `NLCC_ASSERT(a_ovf_len, clk, rst, res_valid && (line_status == ST_OVERFLOW) |-> (line_length == LEN_W'(MAX_LINE)), "overflow length wrong")

  `NLCC_ASSERT(a_sum_zero, clk, rst, res_valid && (line_status != ST_OK) && (line_status != ST_BAD_SUM) |-> (computed_sum == 8'h00), "sum set on non checksum status")

  `NLCC_ASSERT(a_len_max, clk, rst, res_valid |-> (line_length <= LEN_W'(MAX_LINE)), "line length above max")

endmodule

bind nmea_line_checksum_checker_top nlcc_checker u_nlcc_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .line_status  (res.line_status),
  .line_length  (res.line_length),
  .computed_sum (res.computed_sum)
);
